// ===== rtl/core/bat_pkg.sv =====
// Package for the breakpoint address table: table sizes, request opcodes,
// item structs, controller states and the count-to-port helper.
// No dependencies; every module of the block imports it.
package bat_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 16;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_UNSET = 2'd1,
      OP_CLEAR = 2'd2,
      OP_QUERY = 2'd3
   } bat_op_type;

   typedef struct packed {
      bat_op_type          req_type;
      logic [ADDR_W-1:0]   address;
   } bat_req_type;

   typedef struct packed {
      logic                   success;
      logic [COUNT_OUT_W-1:0] entry_count;
   } bat_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_FINISH
   } bat_state_type;

   // The count port shows the low five bits of the internal count.
   function automatic logic [COUNT_OUT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[COUNT_OUT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/breakpoint_address_table.sv =====
// Breakpoint address table top level: the address memory, the scan and
// swap-remove controller and the result register. Depends on bat_pkg.
//
//   channel | direction | payload       | handshake
//   --------+-----------+---------------+-------------------------
//   req_    | in        | bat_req_type  | req_valid / req_ready
//   rsp_    | out       | bat_rsp_type  | rsp_valid / rsp_ready
//
// One item is worked on at a time. Set and clear go from acceptance
// straight to the finish state, which loads the result register. Query
// and unset scan the memory one entry per cycle through its single read
// port, and an unset that finds its address then reads the last entry
// and writes it into the freed slot. Reset clears only the entry count,
// the control state and the valid flags; the memory is never cleared,
// since no entry at or above the count is ever read.
// A stalled result port holds the finished item in the result register.
module breakpoint_address_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bat_pkg::bat_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bat_pkg::bat_rsp_type rsp_data
);
   import bat_pkg::*;

   // The address memory: one write port and one registered read port.
   logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0] mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0] rd_data_ff;

   // Controller state.
   bat_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   bat_op_type        op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              ok_ff, ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bat_rsp_type       rsp_ff, rsp_in;

   logic              accept;
   logic              hit;
   logic              scan_more;
   logic              out_free;
   logic [CNT_W-1:0]  last_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The entry read in the previous cycle matches the address being looked for.
   assign hit       = rd_pend_ff && (rd_data_ff == addr_ff);
   // Entries below the count that have not been read yet remain.
   assign scan_more = (scan_idx_ff < count_ff);
   assign last_pos  = count_ff - CNT_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == OP_UNSET || req_data.req_type == OP_QUERY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               state_in = (op_ff == OP_UNSET) ? ST_SWAP_RD : ST_FINISH;
            end else if (!scan_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_SWAP_RD: begin
            state_in = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls and register updates for each state.
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IDX_W-1:0];
      mem_wdata    = addr_ff;
      mem_re       = 1'b0;
      mem_raddr    = scan_idx_ff[IDX_W-1:0];
      count_in     = count_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      scan_idx_in  = scan_idx_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      pos_in       = pos_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_data.req_type;
               addr_in     = req_data.address;
               scan_idx_in = '0;
               ok_in       = 1'b0;
               unique case (req_data.req_type)
                  OP_SET: begin
                     // A full table drops the address and reports failure.
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[IDX_W-1:0];
                        mem_wdata = req_data.address;
                        count_in  = count_ff + CNT_W'(1);
                        ok_in     = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                  end
                  OP_UNSET, OP_QUERY: begin
                     ok_in = 1'b0;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Reads are issued one per cycle and compared in the cycle after,
            // so the scan stops at the first match.
            priority if (hit) begin
               pos_in = rd_idx_ff;
               ok_in  = 1'b1;
            end else if (scan_more) begin
               mem_re      = 1'b1;
               mem_raddr   = scan_idx_ff[IDX_W-1:0];
               rd_idx_in   = scan_idx_ff[IDX_W-1:0];
               rd_pend_in  = 1'b1;
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end else begin
               ok_in = 1'b0;
            end
         end
         ST_SWAP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = last_pos[IDX_W-1:0];
         end
         ST_SWAP_WR: begin
            // The last entry moves into the freed slot; when the match was
            // the last entry it simply rewrites itself.
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = rd_data_ff;
            count_in  = last_pos;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.success     = ok_ff;
               rsp_in.entry_count = cnt_to_out(count_ff);
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         addr_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= addr_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      pos_ff      <= pos_in;
      ok_ff       <= ok_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== rtl/core/bat_checker.sv =====
// Port-level checker for the breakpoint address table, with the bind that
// attaches it to the top level. Depends on bat_pkg and breakpoint_address_table.
module bat_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input bat_pkg::bat_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bat_pkg::bat_rsp_type rsp_data
);
   import bat_pkg::*;

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Only one item is in work: the block is busy right after an acceptance.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an item was in work");

   // A new result is produced only while the input side is busy.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item in work");

   // The reported count never exceeds the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.entry_count) <= TABLE_DEPTH ||
                     TABLE_DEPTH >= 32))
      else $error("entry count beyond table depth");

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
